### sv/bmw_pkg.sv
`timescale 1ns / 1ps

package bmw_pkg;

	// Slot layout
	localparam int DIRECT_SLOTS        = 12;
	localparam int MAX_LEVELS          = 3;
	localparam int FIRST_INDIRECT_SLOT = 12;
	localparam int SLOT_COUNT          = 15;
	localparam int SLOT_AW             = 4;

	// Inode mode format field
	localparam logic [15:0] FMT_MASK    = 16'hF000;
	localparam logic [15:0] FMT_SYMLINK = 16'hA000;
	localparam logic [31:0] INLINE_LINK_MAX = 32'd60;

	// Request types
	localparam logic [1:0] REQ_LOAD      = 2'd0;
	localparam logic [1:0] REQ_TRANSLATE = 2'd1;
	localparam logic [1:0] REQ_RESPONSE  = 2'd2;

	// Result kinds
	localparam logic KIND_READ   = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	// Result status
	localparam logic [1:0] ST_MAPPED   = 2'd0;
	localparam logic [1:0] ST_UNMAPPED = 2'd1;
	localparam logic [1:0] ST_BUSY     = 2'd2;

	// Register map
	localparam logic REG_LOG_BLOCK_SIZE = 1'b0;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [3:0]  slot_index;
		logic [31:0] word_value;
		logic [30:0] logical_block;
		logic [31:0] file_sectors;
		logic [15:0] file_mode;
		logic [31:0] file_size;
	} in_t;

	typedef struct packed {
		logic        out_kind;
		logic [31:0] read_block;
		logic [9:0]  read_index;
		logic [31:0] phys_block;
		logic [1:0]  status;
	} out_t;

	// Decoded result of one transaction, before the slot read returns
	typedef struct packed {
		logic        has_res;
		logic        use_ram;
		logic        out_kind;
		logic [31:0] read_block;
		logic [9:0]  read_index;
		logic [31:0] phys_block;
		logic [1:0]  status;
	} dec_t;

	// Slot memory access
	typedef struct packed {
		logic               we;
		logic [SLOT_AW-1:0] waddr;
		logic [31:0]        wdata;
		logic               re;
		logic [SLOT_AW-1:0] raddr;
	} mem_req_t;

	function automatic logic [1:0] eff_log(input logic [1:0] raw);
		return (raw == 2'd3) ? 2'd2 : raw;
	endfunction

	// Blocks covered by an indirect tree of the given depth: (256 << lg) ** level
	function automatic logic [31:0] level_span(input logic [1:0] lg, input logic [1:0] level);
		logic [5:0] amt;
		amt = 6'd0;
		case (level)
			2'd1:    amt = 6'd8 + 6'(lg);
			2'd2:    amt = 6'd16 + 6'({lg, 1'b0});
			2'd3:    amt = 6'd24 + 6'({lg, 1'b0}) + 6'(lg);
			default: amt = 6'd0;
		endcase
		return 32'd1 << amt;
	endfunction

	// Word index for the level that still has n reads to go
	function automatic logic [9:0] level_index(input logic [29:0] rel, input logic [1:0] lg,
			input logic [1:0] n);
		logic [29:0] v;
		logic [10:0] mask;
		case (n)
			2'd2:    v = rel >> (5'd8 + 5'(lg));
			2'd3:    v = rel >> (5'd16 + 5'({lg, 1'b0}));
			default: v = rel;
		endcase
		mask = (11'd256 << lg) - 11'd1;
		return v[9:0] & mask[9:0];
	endfunction

endpackage

### sv/block_map_walker.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    in_data  (in_t: load, translate, response)
// out       output     out_valid / out_stall  out_data (out_t: read request or finish)
// apb       config     psel/penable/pready    log_block_size at byte address 0
//
// One transaction accepted per cycle while in_stall is low; its result passes
// through the slot memory read, then the output register.
// Walk state (active, levels left, relative block) updates at acceptance,
// so the next transaction sees it with no bubble.
// Reset clears walk state and log_block_size; pointer slots stay undefined.
// in_stall rises only when both the slot-read stage and out_data are held.

module block_map_walker import bmw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,

	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [1:0]  log_block_size_q;
	logic        accept;
	dec_t        dec;
	mem_req_t    mem_req;
	logic [31:0] slot_rdata;

	// Slot-read stage
	logic        valid_s1;
	dec_t        dec_s1;
	logic        adv_s1;

	logic        out_valid_q;
	out_t        out_data_q;
	out_t        out_next;

	// APB register: one 2-bit field, writes beyond it are dropped
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LOG_BLOCK_SIZE) ? {30'd0, log_block_size_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_block_size_q <= 2'd0;
		end else if (psel && penable && pwrite && pready &&
				paddr[2] == REG_LOG_BLOCK_SIZE) begin
			log_block_size_q <= pwdata[1:0];
		end
	end

	// Pipeline flow control
	assign adv_s1   = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv_s1;
	assign accept   = in_valid && !in_stall;

	bmw_walk_ctl u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (in_data),
		.lg      (eff_log(log_block_size_q)),
		.dec     (dec),
		.mem_req (mem_req)
	);

	bmw_ram #(
		.WIDTH (32),
		.DEPTH (SLOT_COUNT)
	) u_slots (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (slot_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1 || !valid_s1) begin
			valid_s1 <= accept && dec.has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dec_s1 <= dec;
		end
	end

	// Merge slot data: direct map gives phys_block, walk start gives read_block
	always_comb begin
		out_next.out_kind   = dec_s1.out_kind;
		out_next.read_block = dec_s1.read_block;
		out_next.read_index = dec_s1.read_index;
		out_next.phys_block = dec_s1.phys_block;
		out_next.status     = dec_s1.status;
		if (dec_s1.use_ram) begin
			if (dec_s1.out_kind == KIND_READ) begin
				out_next.read_block = slot_rdata;
			end else begin
				out_next.phys_block = slot_rdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			out_data_q <= out_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### sv/bmw_ram.sv
`timescale 1ns / 1ps

module bmw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/bmw_walk_ctl.sv
`timescale 1ns / 1ps

module bmw_walk_ctl import bmw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  in_t        item,
	input  logic [1:0] lg,
	output dec_t       dec,
	output mem_req_t   mem_req
);

	logic        walk_active_q;
	logic [1:0]  levels_left_q;
	logic [29:0] rel_q;

	logic        start_walk;
	logic [1:0]  start_lvl;
	logic [29:0] start_rel;
	logic        finish_walk;
	logic        step_walk;
	logic [1:0]  next_n;

	logic        found;
	logic [31:0] lvl_start;
	logic [31:0] lvl_limit;
	logic [31:0] logical32;
	logic [31:0] blocks_in_file;
	logic        is_inline_link;

	assign logical32      = {1'b0, item.logical_block};
	assign blocks_in_file = item.file_sectors >> (3'd1 + 3'(lg));
	assign is_inline_link = ((item.file_mode & FMT_MASK) == FMT_SYMLINK) &&
		(item.file_size <= INLINE_LINK_MAX);
	assign next_n = levels_left_q - 2'd1;

	always_comb begin
		dec         = '0;
		mem_req     = '0;
		start_walk  = 1'b0;
		start_lvl   = 2'd0;
		start_rel   = '0;
		finish_walk = 1'b0;
		step_walk   = 1'b0;
		found       = 1'b0;
		lvl_start   = 32'(DIRECT_SLOTS);
		lvl_limit   = '0;

		mem_req.waddr = item.slot_index;
		mem_req.wdata = item.word_value;
		mem_req.re    = accept;
		mem_req.raddr = item.logical_block[SLOT_AW-1:0];

		// Range search over the indirect levels
		for (int l = 1; l <= MAX_LEVELS; l++) begin
			lvl_limit = lvl_start + level_span(lg, 2'(l));
			if (!found && logical32 < lvl_limit) begin
				found     = 1'b1;
				start_lvl = 2'(l);
				start_rel = 30'(logical32 - lvl_start);
			end
			lvl_start = lvl_limit;
		end

		case (item.req_type)
			REQ_LOAD: begin
				mem_req.we = accept && (item.slot_index < 4'(SLOT_COUNT));
			end
			REQ_TRANSLATE: begin
				dec.has_res  = 1'b1;
				dec.out_kind = KIND_FINISH;
				if (walk_active_q) begin
					dec.status = ST_BUSY;
				end else if (is_inline_link || logical32 >= blocks_in_file) begin
					dec.status = ST_UNMAPPED;
				end else if (logical32 < 32'(DIRECT_SLOTS)) begin
					dec.use_ram = 1'b1;
					dec.status  = ST_MAPPED;
				end else if (found) begin
					start_walk       = 1'b1;
					dec.use_ram      = 1'b1;
					dec.out_kind     = KIND_READ;
					dec.status       = ST_MAPPED;
					dec.read_index   = level_index(start_rel, lg, start_lvl);
					mem_req.raddr    = SLOT_AW'(FIRST_INDIRECT_SLOT) + SLOT_AW'(start_lvl) -
						SLOT_AW'(1);
				end else begin
					dec.status = ST_UNMAPPED;
				end
			end
			REQ_RESPONSE: begin
				if (walk_active_q) begin
					dec.has_res = 1'b1;
					dec.status  = ST_MAPPED;
					if (next_n == 2'd0) begin
						finish_walk    = 1'b1;
						dec.out_kind   = KIND_FINISH;
						dec.phys_block = item.word_value;
					end else begin
						step_walk      = 1'b1;
						dec.out_kind   = KIND_READ;
						dec.read_block = item.word_value;
						dec.read_index = level_index(rel_q, lg, next_n);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_active_q <= 1'b0;
			levels_left_q <= 2'd0;
			rel_q         <= '0;
		end else if (accept) begin
			if (start_walk) begin
				walk_active_q <= 1'b1;
				levels_left_q <= start_lvl;
				rel_q         <= start_rel;
			end else if (finish_walk) begin
				walk_active_q <= 1'b0;
				levels_left_q <= 2'd0;
			end else if (step_walk) begin
				levels_left_q <= next_n;
			end
		end
	end

endmodule

### sv/bmw_checker.sv
`timescale 1ns / 1ps

module bmw_checker import bmw_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input out_t out_data
);

	// Held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("out_data changed while stalled");

	// An empty output register never back-pressures the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("in_stall with empty output");

	// Read requests carry no phys_block and a mapped status
	a_read_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.out_kind == KIND_READ |->
			out_data.status == ST_MAPPED && out_data.phys_block == 32'd0)
		else $error("read request with finish fields");

	// Finished transactions clear read fields; unmapped ones clear phys_block
	a_finish_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.out_kind == KIND_FINISH |->
			out_data.read_block == 32'd0 && out_data.read_index == 10'd0 &&
			(out_data.status == ST_MAPPED || out_data.phys_block == 32'd0))
		else $error("finish result with stray fields");

endmodule

bind block_map_walker bmw_checker u_bmw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
